// ===== rtl/hlf_pkg.sv =====
// Shared constants, types and helper functions for the Hough line dedup filter.
package hlf_pkg;

  // Store size and field widths
  localparam int MAX_LINES = 64;
  localparam int RHO_W     = 12;
  localparam int THETA_W   = 8;
  localparam int RTOL_W    = 12;
  localparam int TTOL_W    = 8;
  localparam int OUT_CNT_W = 7;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);
  localparam int IDX_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int RCMP_W    = (RHO_W > RTOL_W) ? RHO_W : RTOL_W;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RHO_TOL   = 1'b0,
    REG_THETA_TOL = 1'b1
  } cfg_reg_t;

  localparam logic [RTOL_W-1:0] RHO_TOL_RST   = RTOL_W'(50);
  localparam logic [TTOL_W-1:0] THETA_TOL_RST = TTOL_W'(2);

  // Query token passed from cell to cell
  typedef struct packed {
    logic                     active;
    logic                     matched;
    logic                     kept;
    logic signed [RHO_W-1:0]  rho;
    logic [THETA_W-1:0]       theta;
  } tok_t;

  // |a - b| for signed distances; fits in RHO_W bits unsigned
  function automatic logic [RHO_W-1:0] rho_dist(input logic signed [RHO_W-1:0] a,
                                                input logic signed [RHO_W-1:0] b);
    logic signed [RHO_W:0] d;
    logic        [RHO_W:0] m;
    d = $signed({a[RHO_W-1], a}) - $signed({b[RHO_W-1], b});
    m = d[RHO_W] ? (RHO_W+1)'(-d) : (RHO_W+1)'(d);
    return m[RHO_W-1:0];
  endfunction

  // |a - b| for unsigned angles; no wrap
  function automatic logic [THETA_W-1:0] theta_dist(input logic [THETA_W-1:0] a,
                                                    input logic [THETA_W-1:0] b);
    logic [THETA_W-1:0] r;
    r = (a >= b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage

// ===== rtl/hlf_if.sv =====
// Valid/ready channel interfaces for line beats and result beats.
interface hlf_in_if;
  import hlf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    frame_start;
  logic signed [RHO_W-1:0] rho;
  logic [THETA_W-1:0]      theta_deg;

  modport source (output valid, frame_start, rho, theta_deg, input ready);
  modport sink   (input valid, frame_start, rho, theta_deg, output ready);
endinterface

interface hlf_out_if;
  import hlf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 keep;
  logic                 overflow;
  logic [OUT_CNT_W-1:0] kept_count;

  modport source (output valid, keep, overflow, kept_count, input ready);
  modport sink   (input valid, keep, overflow, kept_count, output ready);
endinterface

// ===== rtl/hough_line_dedup_filter_core.sv =====
// Hough line dedup filter: token walks a chain of store cells, one cell per cycle.
// An input beat is registered in inj_r, passes each cell register of the chain in
//   turn and is registered again in the result register.
// One line is in flight at a time; the next waits till the last leaves the chain.
// Reset: synchronous active-low rst_n empties the store and loads tolerances 50 and 2.
module hough_line_dedup_filter_core
  import hlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  hlf_in_if.sink               in_ch,
  hlf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [RTOL_W-1:0]    rho_tol_r;
  logic [TTOL_W-1:0]    theta_tol_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 busy_r;
  logic                 out_valid_r;
  logic                 keep_r;
  logic                 overflow_r;
  logic [OUT_CNT_W-1:0] kept_count_r;
  tok_t                 inj_r;
  tok_t                 chain [0:MAX_LINES];
  tok_t                 tail;
  logic                 in_fire;
  logic                 done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rho_tol_r   <= RHO_TOL_RST;
      theta_tol_r <= THETA_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RHO_TOL:   rho_tol_r   <= cfg_wdata[RTOL_W-1:0];
        REG_THETA_TOL: theta_tol_r <= cfg_wdata[TTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side: one line in flight, result register must be free
  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign tail = chain[MAX_LINES];
  assign done = tail.active;

  // Token injection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r.active <= 1'b0;
    end else begin
      inj_r.active <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inj_r.matched <= 1'b0;
      inj_r.kept    <= 1'b0;
      inj_r.rho     <= in_ch.rho;
      inj_r.theta   <= in_ch.theta_deg;
    end
  end

  assign chain[0] = inj_r;

  // Cell chain
  genvar g;
  generate
    for (g = 0; g < MAX_LINES; g++) begin : g_cell
      hlf_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .idx       (IDX_W'(g)),
        .count     (count_r),
        .rho_tol   (rho_tol_r),
        .theta_tol (theta_tol_r),
        .tok_in    (chain[g]),
        .tok_out   (chain[g+1])
      );
    end
  endgenerate

  // Fill count: cleared by frame start, bumped when a line is stored
  assign count_nxt = count_r + CNT_W'(tail.kept);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire && in_ch.frame_start) begin
      count_r <= '0;
    end else if (done) begin
      count_r <= count_nxt;
    end
  end

  // Busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_fire) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      keep_r       <= tail.kept;
      overflow_r   <= !tail.matched && !tail.kept;
      kept_count_r <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.keep       = keep_r;
  assign out_ch.overflow   = overflow_r;
  assign out_ch.kept_count = kept_count_r;

endmodule

// ===== rtl/hlf_cell.sv =====
// One store cell: holds a line, compares the passing token, captures new lines.
module hlf_cell
  import hlf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  idx,
  input  logic [CNT_W-1:0]  count,
  input  logic [RTOL_W-1:0] rho_tol,
  input  logic [TTOL_W-1:0] theta_tol,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic signed [RHO_W-1:0] rho_r;
  logic [THETA_W-1:0]      theta_r;
  tok_t                    tok_r;
  tok_t                    tok_nxt;

  logic               occupied;
  logic               free_slot;
  logic [RHO_W-1:0]   d_rho;
  logic [THETA_W-1:0] d_theta;
  logic               similar;
  logic               capture;

  // Entry holds a line when its index is below the fill count
  assign occupied  = CNT_W'(idx) < count;
  assign free_slot = CNT_W'(idx) == count;

  assign d_rho   = rho_dist(tok_in.rho, rho_r);
  assign d_theta = theta_dist(tok_in.theta, theta_r);
  assign similar = occupied
                   && (RCMP_W'(d_rho) < RCMP_W'(rho_tol))
                   && (d_theta < theta_tol);

  // All occupied entries lie ahead of the first free slot
  assign capture = tok_in.active && free_slot && !tok_in.matched;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.active && similar) begin
      tok_nxt.matched = 1'b1;
    end
    if (capture) begin
      tok_nxt.kept = 1'b1;
    end
  end

  // Token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
  end

  // Token payload
  always_ff @(posedge clk) begin
    tok_r.matched <= tok_nxt.matched;
    tok_r.kept    <= tok_nxt.kept;
    tok_r.rho     <= tok_nxt.rho;
    tok_r.theta   <= tok_nxt.theta;
  end

  // Stored line
  always_ff @(posedge clk) begin
    if (capture) begin
      rho_r   <= tok_in.rho;
      theta_r <= tok_in.theta;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== verif/line_verdict_checker.sv =====
// Monitor and scoreboard for the Hough line dedup filter: predicts and checks every result beat.
module line_verdict_checker
  import hlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  hlf_in_if                    line_mon,
  hlf_out_if                   verdict_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   verdicts_owed
);

  typedef struct packed {
    logic                 keep;
    logic                 overflow;
    logic [OUT_CNT_W-1:0] kept_count;
  } verdict_t;

  // Shadow copy of the tolerances and of the line store
  logic [RTOL_W-1:0]       rho_tol;
  logic [TTOL_W-1:0]       ang_tol;
  logic signed [RHO_W-1:0] stored_rho [MAX_LINES];
  logic [THETA_W-1:0]      stored_ang [MAX_LINES];
  int unsigned             stored_n;

  verdict_t pending_verdicts [$];

  initial begin
    fail_count    = 0;
    verdicts_owed = 0;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Judge one line against the store and update it the way the block should
  function automatic verdict_t judge_line(input logic fs, input logic signed [RHO_W-1:0] r,
                                          input logic [THETA_W-1:0] a);
    verdict_t v;
    bit       dup;
    int       dr;
    int       da;
    dup = 1'b0;
    v   = '0;
    if (fs) stored_n = 0;
    for (int i = 0; i < stored_n; i++) begin
      dr = int'(r) - int'(stored_rho[i]);
      da = int'(a) - int'(stored_ang[i]);
      if (dr < 0) dr = -dr;
      if (da < 0) da = -da;
      if (dr < int'(rho_tol) && da < int'(ang_tol)) begin
        dup = 1'b1;
        break;
      end
    end
    if (!dup) begin
      if (stored_n < MAX_LINES) begin
        stored_rho[stored_n] = r;
        stored_ang[stored_n] = a;
        stored_n++;
        v.keep = 1'b1;
      end else begin
        v.overflow = 1'b1;
      end
    end
    v.kept_count = OUT_CNT_W'(stored_n);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      rho_tol  = RHO_TOL_RST;
      ang_tol  = THETA_TOL_RST;
      stored_n = 0;
      pending_verdicts.delete();
    end else begin
      // the user must make register writes land only while the block is idle; nothing here enforces it
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_RHO_TOL:   rho_tol = cfg_wdata[RTOL_W-1:0];
          REG_THETA_TOL: ang_tol = cfg_wdata[TTOL_W-1:0];
          default: ;
        endcase
      end
      // result beat: compare against the oldest prediction first
      if (verdict_mon.valid && verdict_mon.ready) begin
        if (pending_verdicts.size() == 0) begin
          flag_mismatch("unexpected result beat, kept_count", int'(verdict_mon.kept_count), -1);
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict_mon.keep !== want.keep)
            flag_mismatch("keep", int'(verdict_mon.keep), int'(want.keep));
          if (verdict_mon.overflow !== want.overflow)
            flag_mismatch("overflow", int'(verdict_mon.overflow), int'(want.overflow));
          if (verdict_mon.kept_count !== want.kept_count)
            flag_mismatch("kept_count", int'(verdict_mon.kept_count), int'(want.kept_count));
        end
      end
      // line beat: predict its result
      if (line_mon.valid && line_mon.ready)
        pending_verdicts.insert(pending_verdicts.size(),
                                judge_line(line_mon.frame_start, line_mon.rho,
                                           line_mon.theta_deg));
    end
    verdicts_owed = pending_verdicts.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the dedup filter testbench: clock, reset, line and result traffic, verdict.
module testbench;
  import hlf_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 2 * MAX_LINES + 8;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 128;
  localparam int RHO_MAX     = (1 << (RHO_W - 1)) - 1;
  localparam int RHO_MIN     = -(1 << (RHO_W - 1));
  localparam int ANG_MAX     = (1 << THETA_W) - 1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   verdicts_owed;

  bit calm_tx;
  bit calm_rx;
  bit long_hold_req;
  int cur_rho_tol;
  int cur_ang_tol;

  // lines already sent in the current frame, used to aim near-duplicates
  logic signed [RHO_W-1:0] frame_rho [$];
  logic [THETA_W-1:0]      frame_ang [$];

  hlf_in_if  line_ch ();
  hlf_out_if verdict_ch ();

  hough_line_dedup_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (line_ch),
    .out_ch    (verdict_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  line_verdict_checker verdict_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .line_mon      (line_ch),
    .verdict_mon   (verdict_ch),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any beat or register write
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((line_ch.valid && line_ch.ready) || (verdict_ch.valid && verdict_ch.ready) || cfg_we)
        idle = 0;
      else
        idle++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, calm stretches, one long hold-off on request
  initial begin : result_sink
    int stall;
    int beats;
    verdict_ch.ready = 1'b0;
    calm_rx = 1'b0;
    beats = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 16);
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall != 0) begin
        verdict_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      verdict_ch.ready <= 1'b1;
      @(posedge clk);
      while (!verdict_ch.valid) @(posedge clk);
      beats++;
      if (beats % 32 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  // One line beat; starts and ends at a falling edge
  task automatic send_line(input logic fs, input logic signed [RHO_W-1:0] r,
                           input logic [THETA_W-1:0] a);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      line_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    line_ch.valid       <= 1'b1;
    line_ch.frame_start <= fs;
    line_ch.rho         <= r;
    line_ch.theta_deg   <= a;
    @(posedge clk);
    while (!line_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering lines until every result is back, plus a short settle
  task automatic drain_results();
    line_ch.valid <= 1'b0;
    while (verdicts_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_tolerances(input int rtol, input int atol);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RHO_TOL;
    cfg_wdata <= CFG_W'(rtol);
    @(negedge clk);
    cfg_idx   <= REG_THETA_TOL;
    cfg_wdata <= CFG_W'(atol);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_rho_tol = rtol;
    cur_ang_tol = atol;
  endtask

  function automatic logic signed [RHO_W-1:0] near_rho(input logic signed [RHO_W-1:0] base,
                                                       input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v > RHO_MAX) v = RHO_MAX;
    if (v < RHO_MIN) v = RHO_MIN;
    return RHO_W'(v);
  endfunction

  function automatic logic [THETA_W-1:0] near_ang(input logic [THETA_W-1:0] base,
                                                  input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v > ANG_MAX) v = ANG_MAX;
    if (v < 0) v = 0;
    return THETA_W'(v);
  endfunction

  // Frames of lines: mostly fresh or near-duplicate lines, some raw noise
  task automatic run_phase(input int rtol, input int atol, input bit long_first,
                           input bit hold_rx);
    int left;
    int flen;
    int roll;
    int j;
    bit first;
    bit fs;
    logic signed [RHO_W-1:0] r;
    logic [THETA_W-1:0]      a;
    drain_results();
    set_tolerances(rtol, atol);
    left  = PHASE_ITEMS;
    first = 1'b1;
    while (left > 0) begin
      if (long_first) flen = 80;
      else if ($urandom_range(0, 4) == 0) flen = $urandom_range(65, 100);
      else flen = $urandom_range(1, 40);
      long_first = 1'b0;
      frame_rho.delete();
      frame_ang.delete();
      for (int k = 0; k < flen && left > 0; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          r = RHO_W'($urandom);
          a = THETA_W'($urandom);
        end else if (roll < 65 && frame_rho.size() > 0) begin
          j = $urandom_range(0, frame_rho.size() - 1);
          r = near_rho(frame_rho[j], cur_rho_tol + 1);
          a = near_ang(frame_ang[j], cur_ang_tol + 1);
        end else begin
          r = RHO_W'($urandom);
          a = THETA_W'($urandom_range(0, 179));
        end
        // a phase may open without a frame mark and run on the old store
        fs = (k == 0) ? (first ? bit'($urandom_range(0, 1)) : 1'b1) : 1'b0;
        first = 1'b0;
        send_line(fs, r, a);
        frame_rho.insert(frame_rho.size(), r);
        frame_ang.insert(frame_ang.size(), a);
        if (hold_rx && left == PHASE_ITEMS) long_hold_req = 1'b1;
        left--;
        if (left % 32 == 0) calm_tx = ($urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Stimulus
  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = REG_RHO_TOL;
    cfg_wdata           = '0;
    line_ch.valid       = 1'b0;
    line_ch.frame_start = 1'b0;
    line_ch.rho         = '0;
    line_ch.theta_deg   = '0;
    calm_tx             = 1'b0;
    long_hold_req       = 1'b0;
    cur_rho_tol         = int'(RHO_TOL_RST);
    cur_ang_tol         = int'(THETA_TOL_RST);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset tolerances: similarity edges, field extremes, no wrap
    send_line(1'b1, 12'sd0, 8'd0);
    send_line(1'b0, 12'sd49, 8'd1);         // just inside both tolerances
    send_line(1'b0, 12'sd50, 8'd0);         // distance exactly at tolerance
    send_line(1'b0, -12'sd2048, 8'd179);
    send_line(1'b0, 12'sd2047, 8'd179);
    send_line(1'b0, -12'sd1999, 8'd178);
    send_line(1'b0, 12'sd2047, 8'd180);     // out-of-range angle vs 179
    send_line(1'b0, 12'sd2047, 8'd255);
    send_line(1'b0, 12'sd2000, 8'd254);
    send_line(1'b0, -12'sd1, 8'd128);
    send_line(1'b0, 12'sd1, 8'd129);
    send_line(1'b1, 12'sd0, 8'd0);          // new frame empties the store
    send_line(1'b1, -12'sd2048, 8'd255);
    send_line(1'b0, 12'sh555, 8'haa);
    send_line(1'b0, 12'shaaa, 8'h55);

    // zero tolerance: identical lines are all new
    drain_results();
    set_tolerances(0, 0);
    send_line(1'b1, 12'sd5, 8'd5);
    send_line(1'b0, 12'sd5, 8'd5);
    send_line(1'b0, 12'sd5, 8'd5);

    // random phases over several tolerance settings
    run_phase(0, 0, 1'b1, 1'b0);            // fills the store past full
    run_phase(int'(RHO_TOL_RST), int'(THETA_TOL_RST), 1'b0, 1'b0);
    run_phase(4095, 180, 1'b0, 1'b1);
    run_phase(1, 1, 1'b0, 1'b0);
    run_phase(12, 6, 1'b0, 1'b0);
    run_phase(300, 30, 1'b0, 1'b0);
    run_phase($urandom_range(0, 4095), $urandom_range(0, 180), 1'b0, 1'b0);
    run_phase(0, 180, 1'b0, 1'b0);

    line_ch.valid <= 1'b0;
    while (verdicts_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
